// ===== src/tof_pkg.sv =====
// ----------------------------------------------------------------------------
// tof_pkg: shared constants for the flight-time to m/z converter
// Field widths, register indexes and calibration constants.
// ----------------------------------------------------------------------------
package tof_pkg;

	localparam int TIME_W     = 40;
	localparam int MZ_W       = 40;
	localparam int SCALE_W    = 48;
	localparam int OFFS_W     = 40;
	localparam int THIRD_W    = 48;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 48;

	localparam int MZ_FRAC_BITS_DEF = 16;
	localparam int QUO_BITS         = 40;

	// radicand and root widths in three-point mode
	localparam int RAD_W  = 144;
	localparam int ROOT_W = RAD_W / 2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFS  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THIRD = 8'd3;

	localparam logic [THIRD_W-1:0] THIRD_RESET = 48'h0001_0000_0000;
	localparam logic [MZ_W-1:0]    MZ_MAX      = 40'hFF_FFFF_FFFF;

	localparam logic [9:0]        TIME_MUL   = 10'd1000;
	localparam logic [63:0]       CAL_SCALE  = 64'd1000000000000;
	localparam logic [RAD_W-1:0]  RAD_BIAS   = 144'd250000000000 << 64;
	localparam logic [ROOT_W-1:0] HALF_ROOT  = 72'd500000 << 32;

endpackage

// ===== src/tof_in_if.sv =====
// ----------------------------------------------------------------------------
// tof_in_if: peak time channel
// Valid/ready channel carrying one flight time per transfer.
// ----------------------------------------------------------------------------
interface tof_in_if;
	logic                       valid;
	logic                       ready;
	logic [tof_pkg::TIME_W-1:0] flight_time;

	modport source (output valid, output flight_time, input ready);
	modport sink   (input valid, input flight_time, output ready);
endinterface

// ===== src/tof_out_if.sv =====
// ----------------------------------------------------------------------------
// tof_out_if: m/z result channel
// Valid/ready channel carrying one m/z value and a fault flag per transfer.
// ----------------------------------------------------------------------------
interface tof_out_if;
	logic                     valid;
	logic                     ready;
	logic [tof_pkg::MZ_W-1:0] mass_to_charge;
	logic                     fault;

	modport source (output valid, output mass_to_charge, output fault, input ready);
	modport sink   (input valid, input mass_to_charge, input fault, output ready);
endinterface

// ===== src/tof_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tof_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface tof_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tof_pkg::CFG_IDX_W-1:0]  index;
	logic [tof_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/tof_mul_pipe.sv =====
// ----------------------------------------------------------------------------
// tof_mul_pipe: pipelined multiplier
// Multiplies A by B one CH-bit digit of B per stage, carrying sideband bits.
// ----------------------------------------------------------------------------
module tof_mul_pipe #(
	parameter int WA = 48,
	parameter int WB = 52,
	parameter int SW = 1,
	parameter int CH = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_v,
	input  logic [WA-1:0] a,
	input  logic [WB-1:0] b,
	input  logic [SW-1:0] side,
	output logic          out_v,
	output logic [WA+WB-1:0] p,
	output logic [SW-1:0] side_o
);
	localparam int NS = (WB + CH - 1) / CH;
	localparam int BP = NS * CH;
	localparam int PW = WA + WB;

	logic [NS-1:0] v_s;
	logic [WA-1:0] a_s   [NS];
	logic [BP-1:0] b_s   [NS];
	logic [PW-1:0] acc_s [NS];
	logic [SW-1:0] side_s[NS];
	logic [BP-1:0] b_ext;

	assign b_ext = BP'(b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[NS-2+1-1:0], in_v} >> 0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s[0]    <= a;
			b_s[0]    <= b_ext;
			side_s[0] <= side;
			acc_s[0]  <= PW'(a) * PW'(b_ext[CH-1:0]);
			for (int k = 1; k < NS; k++) begin
				a_s[k]    <= a_s[k-1];
				b_s[k]    <= b_s[k-1];
				side_s[k] <= side_s[k-1];
				acc_s[k]  <= acc_s[k-1]
					+ ((PW'(a_s[k-1]) * PW'(b_s[k-1][k*CH +: CH])) << (k*CH));
			end
		end
	end

	assign out_v  = v_s[NS-1];
	assign p      = acc_s[NS-1];
	assign side_o = side_s[NS-1];
endmodule

// ===== src/tof_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// tof_sqrt_pipe: pipelined integer square root
// Restoring square root, one root bit per stage, floor of sqrt(rad).
// ----------------------------------------------------------------------------
module tof_sqrt_pipe #(
	parameter int RW = 144,
	parameter int SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic            in_v,
	input  logic [RW-1:0]   rad,
	input  logic [SW-1:0]   side,
	output logic            out_v,
	output logic [RW/2-1:0] root,
	output logic [SW-1:0]   side_o
);
	localparam int QW = RW / 2;
	localparam int EW = RW + 2;

	logic [QW-1:0] v_s;
	logic [EW-1:0] rem_s [QW];
	logic [QW-1:0] res_s [QW];
	logic [SW-1:0] side_s[QW];

	logic [EW-1:0] rem_in[QW];
	logic [EW-1:0] rem_nx[QW];
	logic [EW-1:0] trial [QW];
	logic [QW-1:0] res_in[QW];
	logic [QW-1:0] res_nx[QW];

	// remainder tracks rad - res^2; trial is (2*res + 2^b) * 2^b
	always_comb begin
		int b;
		for (int j = 0; j < QW; j++) begin
			b = QW - 1 - j;
			if (j == 0) begin
				rem_in[j] = EW'(rad);
				res_in[j] = '0;
			end else begin
				rem_in[j] = rem_s[j-1];
				res_in[j] = res_s[j-1];
			end
			trial[j] = (EW'(res_in[j]) << (b + 1)) | (EW'(1) << (2 * b));
			if (rem_in[j] >= trial[j]) begin
				rem_nx[j] = rem_in[j] - trial[j];
				res_nx[j] = res_in[j] | (QW'(1) << b);
			end else begin
				rem_nx[j] = rem_in[j];
				res_nx[j] = res_in[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[QW-2:0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side;
			for (int j = 1; j < QW; j++) begin
				side_s[j] <= side_s[j-1];
			end
			for (int j = 0; j < QW; j++) begin
				rem_s[j] <= rem_nx[j];
				res_s[j] <= res_nx[j];
			end
		end
	end

	assign out_v  = v_s[QW-1];
	assign root   = res_s[QW-1];
	assign side_o = side_s[QW-1];
endmodule

// ===== src/tof_div_pipe.sv =====
// ----------------------------------------------------------------------------
// tof_div_pipe: pipelined restoring divider
// Produces QB quotient bits plus an overflow bit, one bit per stage.
// ----------------------------------------------------------------------------
module tof_div_pipe #(
	parameter int NW = 144,
	parameter int DW = 120,
	parameter int QB = 40,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_v,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic          out_v,
	output logic [QB:0]   quo,
	output logic [SW-1:0] side_o
);
	localparam int NS = QB + 1;
	localparam int XW = (NW > DW + QB) ? NW : DW + QB;

	logic [NS-1:0] v_s;
	logic [XW-1:0] rem_s [NS];
	logic [DW-1:0] den_s [NS];
	logic [QB:0]   quo_s [NS];
	logic [SW-1:0] side_s[NS];

	logic [XW-1:0] rem_in[NS];
	logic [XW-1:0] rem_nx[NS];
	logic [XW-1:0] dsh   [NS];
	logic [DW-1:0] den_in[NS];
	logic [QB:0]   quo_in[NS];
	logic [QB:0]   quo_nx[NS];

	// top stage tests num >= den << QB, which flags overflow
	always_comb begin
		int i;
		for (int j = 0; j < NS; j++) begin
			i = QB - j;
			if (j == 0) begin
				rem_in[j] = XW'(num);
				den_in[j] = den;
				quo_in[j] = '0;
			end else begin
				rem_in[j] = rem_s[j-1];
				den_in[j] = den_s[j-1];
				quo_in[j] = quo_s[j-1];
			end
			dsh[j] = XW'(den_in[j]) << i;
			if (rem_in[j] >= dsh[j]) begin
				rem_nx[j] = rem_in[j] - dsh[j];
				quo_nx[j] = quo_in[j] | ((QB+1)'(1) << i);
			end else begin
				rem_nx[j] = rem_in[j];
				quo_nx[j] = quo_in[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[NS-2:0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side;
			for (int j = 1; j < NS; j++) begin
				side_s[j] <= side_s[j-1];
			end
			for (int j = 0; j < NS; j++) begin
				rem_s[j] <= rem_nx[j];
				den_s[j] <= den_in[j];
				quo_s[j] <= quo_nx[j];
			end
		end
	end

	assign out_v  = v_s[NS-1];
	assign quo    = quo_s[NS-1];
	assign side_o = side_s[NS-1];
endmodule

// ===== src/tof_flight_time_to_mz_top.sv =====
// ----------------------------------------------------------------------------
// tof_flight_time_to_mz_top: flight time to m/z converter
// Two-point linear or three-point square-root mass calibration.
// ----------------------------------------------------------------------------
// Channels: cfg writes the four calibration registers (mode, scale, offset,
// third coefficient) by index; it is always ready and unknown indexes are
// dropped. Write registers only while no peak is in flight.
// peak carries one flight time per transfer, mz returns one m/z value and a
// fault flag per peak, in order.
// Pipeline: 140 register stages in all; the 72-bit square root (one bit per
// stage) and the 41-stage divider make up most of them, the multipliers
// take one 8-bit digit a stage.
// Throughput: one peak per cycle while mz is not stalled.
// Reset clears all valid bits and loads mode 0, scale 0, offset 0, third 1.0.
// When mz stalls the whole pipeline holds; the input stage still takes one
// more peak if it is empty, then peak.ready drops until mz is taken.
// ----------------------------------------------------------------------------
module tof_flight_time_to_mz_top #(
	parameter int MZ_FRAC_BITS = tof_pkg::MZ_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tof_cfg_if.sink   cfg,
	tof_in_if.sink    peak,
	tof_out_if.source mz
);
	import tof_pkg::*;

	localparam int X_W    = 53;
	localparam int MAG_W  = 52;
	localparam int P1_W   = SCALE_W + MAG_W;
	localparam int P2_W   = P1_W + MAG_W;
	localparam int P_TWO  = 100;
	localparam int M3A_W  = P_TWO;
	localparam int M4A_W  = ROOT_W + 2;
	localparam int M3_W   = M3A_W + MAG_W;
	localparam int M4_W   = M4A_W + MAG_W;
	localparam int NUM_LO = 120;
	localparam int NUM_W  = NUM_LO + 8 + MZ_FRAC_BITS;
	localparam int DEN_W  = 120;
	localparam logic [M4A_W-1:0] DEN_TWO = M4A_W'(CAL_SCALE) << (32 - MZ_FRAC_BITS);

	// configuration registers
	logic               mode_q;
	logic [SCALE_W-1:0] scale_q;
	logic [OFFS_W-1:0]  offset_q;
	logic [THIRD_W-1:0] third_q;
	logic [THIRD_W-1:0] c_mag;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			scale_q  <= '0;
			offset_q <= '0;
			third_q  <= THIRD_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MODE:  mode_q   <= cfg.data[0];
				REG_SCALE: scale_q  <= cfg.data[SCALE_W-1:0];
				REG_OFFS:  offset_q <= cfg.data[OFFS_W-1:0];
				REG_THIRD: third_q  <= cfg.data[THIRD_W-1:0];
				default: ;
			endcase
		end
	end

	assign c_mag = third_q[THIRD_W-1] ? THIRD_W'(-$signed(third_q)) : third_q;

	logic adv;
	logic mz_v_q;

	assign adv = !mz_v_q || mz.ready;

	// input stage
	logic              v_s1;
	logic [TIME_W-1:0] t_s1;
	logic              en1;

	assign en1        = adv || !v_s1;
	assign peak.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= peak.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			t_s1 <= peak.flight_time;
		end
	end

	// offset-corrected time: 1000*t - 256*ml2 or t - 256*ml2
	logic signed [X_W-1:0] x_base, x_ofs, x_val;
	logic                  v_s2, neg_s2;
	logic [MAG_W-1:0]      mag_s2;

	always_comb begin
		x_base = mode_q ? X_W'(t_s1) : X_W'(t_s1) * X_W'(TIME_MUL);
		x_ofs  = {{(X_W-OFFS_W-8){offset_q[OFFS_W-1]}}, offset_q, 8'h00};
		x_val  = x_base - x_ofs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2 <= x_val[X_W-1];
			mag_s2 <= x_val[X_W-1] ? MAG_W'(-x_val) : x_val[MAG_W-1:0];
		end
	end

	// ml1 * |ml3| (three-point) or ml1 * |d| (two-point)
	logic              m1_v;
	logic [P1_W-1:0]   m1_p;
	logic [MAG_W:0]    m1_side;

	tof_mul_pipe #(.WA(SCALE_W), .WB(MAG_W), .SW(MAG_W + 1)) u_mul1 (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_v(v_s2), .a(scale_q),
		.b(mode_q ? MAG_W'(c_mag) : mag_s2),
		.side({mag_s2, neg_s2}),
		.out_v(m1_v), .p(m1_p), .side_o(m1_side)
	);

	logic              m2_v;
	logic [P2_W-1:0]   m2_p;
	logic [MAG_W:0]    m2_side;

	tof_mul_pipe #(.WA(P1_W), .WB(MAG_W), .SW(MAG_W + 1)) u_mul2 (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_v(m1_v), .a(m1_p),
		.b(mode_q ? m1_side[MAG_W:1] : MAG_W'(1)),
		.side(m1_side),
		.out_v(m2_v), .p(m2_p), .side_o(m2_side)
	);

	// radicand 2.5e11 * 2^64 +/- ml1 * ml3 * u
	logic              v_s3, neg_s3, fmax_s3;
	logic [RAD_W-1:0]  rad_s3;
	logic [P_TWO-1:0]  p_s3;
	logic [MAG_W-1:0]  mag_s3;
	logic              rad_sub, rad_over, zero_div;

	assign rad_sub  = m2_side[0] != third_q[THIRD_W-1];
	assign rad_over = rad_sub && (m2_p > P2_W'(RAD_BIAS));
	assign zero_div = (scale_q == '0) || (third_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= m2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3  <= rad_sub ? RAD_BIAS - m2_p[RAD_W-1:0] : RAD_BIAS + m2_p[RAD_W-1:0];
			p_s3    <= m2_p[P_TWO-1:0];
			mag_s3  <= m2_side[MAG_W:1];
			neg_s3  <= m2_side[0];
			fmax_s3 <= mode_q && (zero_div || rad_over);
		end
	end

	localparam int SQ_SW = P_TWO + MAG_W + 2;

	logic              sq_v;
	logic [ROOT_W-1:0] sq_root;
	logic [SQ_SW-1:0]  sq_side;

	tof_sqrt_pipe #(.RW(RAD_W), .SW(SQ_SW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_v(v_s3), .rad(rad_s3),
		.side({p_s3, mag_s3, neg_s3, fmax_s3}),
		.out_v(sq_v), .root(sq_root), .side_o(sq_side)
	);

	// q - 5e5 and q + 5e5 in 32-bit fraction
	logic              v_s4, neg_s4, fmax_s4, sqn;
	logic [M3A_W-1:0]  a3_s4;
	logic [MAG_W-1:0]  b3_s4;
	logic [M4A_W-1:0]  a4_s4;
	logic [MAG_W-1:0]  b4_s4;
	logic [ROOT_W-1:0] q_dif;
	logic [ROOT_W:0]   q_sum;

	always_comb begin
		sqn   = sq_root < HALF_ROOT;
		q_dif = sqn ? HALF_ROOT - sq_root : sq_root - HALF_ROOT;
		q_sum = (ROOT_W+1)'(sq_root) + (ROOT_W+1)'(HALF_ROOT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a3_s4   <= mode_q ? M3A_W'(q_dif) : sq_side[SQ_SW-1 -: P_TWO];
			b3_s4   <= mode_q ? sq_side[MAG_W+1:2] : MAG_W'(1);
			a4_s4   <= mode_q ? M4A_W'(q_sum) : DEN_TWO;
			b4_s4   <= mode_q ? MAG_W'(c_mag) : MAG_W'(1);
			neg_s4  <= mode_q ? (sq_side[1] ^ sqn ^ third_q[THIRD_W-1]) : sq_side[1];
			fmax_s4 <= sq_side[0];
		end
	end

	logic            m3_v, m3_neg, m4_fmax;
	logic [M3_W-1:0] m3_p;
	logic [M4_W-1:0] m4_p;

	tof_mul_pipe #(.WA(M3A_W), .WB(MAG_W), .SW(1)) u_mul_num (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_v(v_s4), .a(a3_s4), .b(b3_s4), .side(neg_s4),
		.out_v(m3_v), .p(m3_p), .side_o(m3_neg)
	);

	tof_mul_pipe #(.WA(M4A_W), .WB(MAG_W), .SW(1)) u_mul_den (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_v(v_s4), .a(a4_s4), .b(b4_s4), .side(fmax_s4),
		.out_v(), .p(m4_p), .side_o(m4_fmax)
	);

	// numerator scaling; a negative nonzero quotient reports zero
	logic              v_s5, negz_s5, fmax_s5;
	logic [NUM_W-1:0]  num_s5;
	logic [DEN_W-1:0]  den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= m3_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s5  <= NUM_W'(m3_p[NUM_LO-1:0]) << (mode_q ? 8 + MZ_FRAC_BITS : MZ_FRAC_BITS);
			den_s5  <= m4_p[DEN_W-1:0];
			negz_s5 <= m3_neg && (m3_p != '0);
			fmax_s5 <= m4_fmax;
		end
	end

	logic              dv_v;
	logic [QUO_BITS:0] dv_q;
	logic [1:0]        dv_side;

	tof_div_pipe #(.NW(NUM_W), .DW(DEN_W), .QB(QUO_BITS), .SW(2)) u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv),
		.in_v(v_s5), .num(num_s5), .den(den_s5), .side({negz_s5, fmax_s5}),
		.out_v(dv_v), .quo(dv_q), .side_o(dv_side)
	);

	// output register
	logic [MZ_W-1:0] mz_q;
	logic            fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mz_v_q <= 1'b0;
		end else if (adv) begin
			mz_v_q <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (dv_side[0]) begin
				mz_q <= MZ_MAX;
			end else if (dv_side[1]) begin
				mz_q <= '0;
			end else if (dv_q[QUO_BITS]) begin
				mz_q <= MZ_MAX;
			end else begin
				mz_q <= dv_q[MZ_W-1:0];
			end
			fault_q <= dv_side[0] || dv_side[1] || dv_q[QUO_BITS];
		end
	end

	assign mz.valid          = mz_v_q;
	assign mz.mass_to_charge = mz_q;
	assign mz.fault          = fault_q;
endmodule

// ===== src/tof_checker.sv =====
// ----------------------------------------------------------------------------
// tof_checker: port-level checks for the m/z converter
// Watches the result and peak channels of the top level.
// ----------------------------------------------------------------------------
module tof_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     peak_ready,
	input logic                     mz_valid,
	input logic                     mz_ready,
	input logic [tof_pkg::MZ_W-1:0] mz_value,
	input logic                     mz_fault
);
	import tof_pkg::*;

	// a faulted result is always clamped to one of the two rails
	a_fault_rail: assert property (@(posedge clk) disable iff (!arst_n)
		mz_valid && mz_fault |-> (mz_value == '0) || (mz_value == MZ_MAX))
		else $error("fault result not saturated");

	// with the output register empty the pipeline always moves
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!mz_valid |-> peak_ready)
		else $error("peak stalled with empty output");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mz_valid && !mz_ready |=> mz_valid && $stable(mz_value) && $stable(mz_fault))
		else $error("stalled result changed");
endmodule

bind tof_flight_time_to_mz_top tof_checker u_tof_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.peak_ready(peak.ready),
	.mz_valid  (mz.valid),
	.mz_ready  (mz.ready),
	.mz_value  (mz.mass_to_charge),
	.mz_fault  (mz.fault)
);

// ===== tb/sv/tof_flight_time_to_mz_top_tb.sv =====
// ----------------------------------------------------------------------------
// tof_flight_time_to_mz_top_tb: self-checking bench for the m/z converter
// Loads calibration sets while idle, streams peak times with random gaps and
// result stalls, and compares every m/z transfer with a bit-exact predictor.
// ----------------------------------------------------------------------------
module tof_flight_time_to_mz_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tof_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'd200; // not a register
	localparam int DRAIN_CYCLES = 200;
	localparam int STALL_LIMIT  = 5000;

	typedef struct packed {
		logic [MZ_W-1:0] mass;
		logic            fault;
	} mz_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tof_cfg_if cfg_if ();
	tof_in_if  peak_if ();
	tof_out_if mz_if ();

	tof_flight_time_to_mz_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.peak   (peak_if),
		.mz     (mz_if)
	);

	always #6 clk = ~clk;

	// calibration as the bench believes it is loaded
	logic                 mode_q;
	logic [SCALE_W-1:0]   scale_q;
	logic [OFFS_W-1:0]    offs_q;
	logic [THIRD_W-1:0]   third_q;

	logic [TIME_W-1:0] times_pending[$];
	mz_t               mz_expected[$];
	int  errors = 0;
	bit  calm = 1'b0;
	bit  peak_taken = 1'b0;
	int  send_gap = 0;
	int  recv_gap = 0;
	int  stall_cnt = 0;

	function automatic void queue_peak(logic [TIME_W-1:0] t);
		times_pending = {times_pending, t};
	endfunction

	function automatic mz_t saturate_quotient(logic [191:0] num, logic [191:0] den, bit neg);
		logic [191:0] quo;
		mz_t r;
		r.fault = 1'b1;
		if (neg && num != 0) begin
			r.mass = '0;
			return r;
		end
		quo = num / den;
		if (quo > {152'd0, MZ_MAX}) begin
			r.mass = MZ_MAX;
			return r;
		end
		r.mass  = quo[MZ_W-1:0];
		r.fault = 1'b0;
		return r;
	endfunction

	function automatic mz_t convert_time(logic [TIME_W-1:0] t);
		longint ofs, coef, d, u;
		logic [191:0] s, cm, x, p, k, rad, root, cand, h, num, den;
		bit su, sc, sqn;
		mz_t r;
		ofs  = longint'($signed(offs_q));
		coef = longint'($signed(third_q));
		s    = {144'd0, scale_q};
		if (!mode_q) begin
			d   = longint'({24'd0, t}) * 1000 - ofs * 256;
			x   = (d < 0) ? 192'(-d) : 192'(d);
			num = (s * x) << MZ_FRAC_BITS_DEF;
			den = 192'd1000000000000 << (32 - MZ_FRAC_BITS_DEF);
			return saturate_quotient(num, den, d < 0);
		end
		if (scale_q == 0 || third_q == 0) begin
			r.mass  = MZ_MAX;
			r.fault = 1'b1;
			return r;
		end
		u  = longint'({24'd0, t}) - ofs * 256;
		su = u < 0;
		sc = coef < 0;
		cm = sc ? 192'(-coef) : 192'(coef);
		x  = su ? 192'(-u) : 192'(u);
		p  = s * cm * x;
		k  = 192'd250000000000 << 64;
		if (su != sc) begin
			if (p > k) begin
				r.mass  = MZ_MAX;
				r.fault = 1'b1;
				return r;
			end
			rad = k - p;
		end else begin
			rad = k + p;
		end
		root = '0;
		for (int b = 95; b >= 0; b--) begin
			cand = root | (192'd1 << b);
			if (cand * cand <= rad) root = cand;
		end
		h   = 192'd500000 << 32;
		sqn = root < h;
		num = (sqn ? h - root : root - h) * x;
		num = num << (8 + MZ_FRAC_BITS_DEF);
		den = (root + h) * cm;
		return saturate_quotient(num, den, su ^ sqn ^ sc);
	endfunction

	// value with a random bit length so all magnitudes show up
	function automatic logic [63:0] rand_mag(int w);
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v >> (64 - $urandom_range(1, w));
	endfunction

	function automatic logic [63:0] rand_signed(int w);
		logic [63:0] v;
		v = rand_mag(w - 1);
		if ($urandom_range(0, 1)) v = -v;
		return v;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_MODE:  mode_q  = val[0];
			REG_SCALE: scale_q = val[SCALE_W-1:0];
			REG_OFFS:  offs_q  = val[OFFS_W-1:0];
			REG_THIRD: third_q = val[THIRD_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic load_cal(logic m, logic [63:0] s, logic [63:0] o, logic [63:0] c);
		write_reg(REG_MODE, {47'd0, m});
		write_reg(REG_SCALE, s[SCALE_W-1:0]);
		write_reg(REG_OFFS, {8'd0, o[OFFS_W-1:0]});
		write_reg(REG_THIRD, c[THIRD_W-1:0]);
	endtask

	task automatic drain();
		while (times_pending.size() != 0 || mz_expected.size() != 0 || peak_if.valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_random(int n);
		for (int i = 0; i < n; i++) queue_peak(TIME_W'(rand_mag(TIME_W)));
	endtask

	// peak driver
	always @(negedge clk) begin
		if (!peak_if.valid || peak_taken) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				peak_if.valid <= 1'b0;
			end else if (times_pending.size() != 0) begin
				peak_if.valid       <= 1'b1;
				peak_if.flight_time <= times_pending.pop_front();
				if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 6);
			end else begin
				peak_if.valid <= 1'b0;
			end
		end
	end

	// result backpressure
	always @(negedge clk) begin
		if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			mz_if.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			recv_gap <= $urandom_range(0, 5);
			mz_if.ready <= 1'b0;
		end else begin
			mz_if.ready <= 1'b1;
		end
	end

	// transfer monitor and checker
	always @(posedge clk) begin
		mz_t want;
		peak_taken <= peak_if.valid && peak_if.ready;
		if (peak_if.valid && peak_if.ready)
			mz_expected = {mz_expected, convert_time(peak_if.flight_time)};
		if (mz_if.valid && mz_if.ready) begin
			if (mz_expected.size() == 0) begin
				$error("unexpected m/z transfer: mass_to_charge %h fault %b",
					mz_if.mass_to_charge, mz_if.fault);
				errors++;
			end else begin
				want = mz_expected.pop_front();
				if (mz_if.mass_to_charge !== want.mass) begin
					$error("mass_to_charge: expected %h, got %h", want.mass,
						mz_if.mass_to_charge);
					errors++;
				end
				if (mz_if.fault !== want.fault) begin
					$error("fault: expected %b, got %b", want.fault, mz_if.fault);
					errors++;
				end
			end
		end
	end

	// watchdog on transfer-free stretches
	always @(posedge clk) begin
		if ((peak_if.valid && peak_if.ready) || (mz_if.valid && mz_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			stall_cnt <= 0;
		else if (stall_cnt >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else
			stall_cnt <= stall_cnt + 1;
	end

	initial begin
		logic [63:0] s, o, c;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data  = '0;
		peak_if.valid = 1'b0;
		peak_if.flight_time = '0;
		mz_if.ready = 1'b0;
		mode_q  = 1'b0;
		scale_q = '0;
		offs_q  = '0;
		third_q = THIRD_RESET;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset calibration: everything converts to zero
		queue_peak('0);
		queue_peak('1);
		drain();

		// two-point, full scale: overflow, negative difference, offset extremes
		load_cal(1'b0, 64'hFFFF_FFFF_FFFF, 64'h7F_FFFF_FFFF, THIRD_RESET);
		queue_peak('0);
		queue_peak('1);
		queue_peak(40'd1 << 39);
		drain();
		load_cal(1'b0, 64'd256, -64'sd549755813888, THIRD_RESET);
		queue_peak('0);
		queue_peak('1);
		queue_peak(40'h55_5555_5555);
		drain();

		// three-point: zero scale, zero third coefficient, unknown index ignored
		load_cal(1'b1, 64'd0, 64'd0, THIRD_RESET);
		queue_peak(40'd12345);
		drain();
		load_cal(1'b1, 64'd1000, 64'd0, 64'd0);
		write_reg(REG_NONE, 48'hFFFF_FFFF_FFFF);
		queue_peak(40'd12345);
		drain();

		// three-point: negative radicand and negative u with negative ml3
		load_cal(1'b1, 64'hFFFF_FFFF_FFFF, 64'h7F_FFFF_FFFF, 64'h8000_0000_0000);
		queue_peak('0);
		queue_peak('1);
		queue_peak(40'hAA_AAAA_AAAA);
		drain();
		load_cal(1'b1, 64'd256 << 8, 64'd100 << 16, THIRD_RESET);
		queue_peak('0);
		queue_peak('1);
		queue_peak(40'd50 << 24);
		queue_peak(40'd1);
		drain();
		load_cal(1'b1, 64'hFFFF_FFFF_FFFF, -64'sd549755813888, 64'h7FFF_FFFF_FFFF);
		queue_peak('0);
		queue_peak('1);
		drain();

		// random calibration sets with random peak streams
		for (int ph = 0; ph < 13; ph++) begin
			s = rand_mag(SCALE_W);
			o = rand_signed(OFFS_W);
			c = rand_signed(THIRD_W);
			if (ph == 3) c = 64'h7FFF_FFFF_FFFF;
			if (ph == 4) s = 64'hFFFF_FFFF_FFFF;
			load_cal(ph[0], s, o, c);
			if (ph == 12) calm = 1'b1;
			send_random(100);
			drain();
		end

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
